FILE: hdl/mmcs_pkg.sv
// Shared widths and interface types of the min-max contrast stretch block.
package mmcs_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned ProdW = 2 * PixW;
  localparam int unsigned CntW  = $clog2(PixW);
  localparam int unsigned OutW  = 3 * PixW;
  localparam int unsigned UserW = 2;
  localparam int unsigned AddrW = 3;
  localparam int unsigned RegW  = 32;

  localparam logic OpMeasure = 1'b0;
  localparam logic OpApply   = 1'b1;

  localparam logic RegLower = 1'b0;
  localparam logic RegUpper = 1'b1;

  typedef struct packed {
    logic             start;
    logic [ProdW-1:0] num;
    logic [PixW-1:0]  den;
  } div_ctl_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [PixW-1:0] quo;
  } div_sts_t;

  typedef struct packed {
    logic [PixW-1:0] lower;
    logic [PixW-1:0] upper;
  } bounds_t;

endpackage

FILE: hdl/minmax_contrast_stretch.sv
// Top level of the min-max contrast stretch: sequencer, frame statistics and output register.
//
// The frame is streamed twice on the slave channel. tuser[0] selects the
// transaction kind: 0 measures the sample into the running minimum and
// maximum, 1 applies the stretch and returns one result transaction.
// tuser[1] on a measure transaction restarts the minimum and maximum.
// A measure transaction gives no result; the block is ready again in the next cycle.
// An apply transaction passes from acceptance to the result register through
// a preparation state with the 8x8 multiply, the shared shift-subtract
// divider (eight quotient bits, then a hand-over) and a final state that
// forms the result.
// Samples outside the measured range, or a flat range, skip the divider and
// go straight from preparation to the final state. The block is not ready while busy.
// The result register decouples the master channel: a new transaction is
// accepted while a result still waits; a stalled receiver holds the data
// and blocks the next apply result from entering the result register.
// Reset clears the statistics (minimum 255, maximum 0), sets the bounds to
// 0 and 255 and empties the result register.
module minmax_contrast_stretch (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // sample
  input  logic [1:0]                    s_axis_tuser,  // operation, frame_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,  // stretched, frame_min, frame_max
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import mmcs_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPrep = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [PixW-1:0]  min_q, max_q;
  logic [PixW-1:0]  sample_q;
  logic             spec_q;
  logic [PixW-1:0]  spec_val_q;
  logic             neg_q;
  logic [PixW-1:0]  out_q;
  logic [OutW-1:0]  tdata_q;
  logic             tvalid_q;
  bounds_t          bounds;
  div_ctl_t         div_ctl;
  div_sts_t         div_sts;
  logic             in_acc;
  logic             out_free;
  logic             load_out;
  logic             flat, below, above, special;
  logic [PixW-1:0]  span, offs, rng;
  logic [ProdW-1:0] prod;
  logic [PixW-1:0]  result;

  mmcs_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .bounds_o (bounds)
  );

  mmcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .sts_o  (div_sts)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !tvalid_q || m_axis_tready;

  always_comb begin
    flat    = (max_q <= min_q);
    below   = (sample_q < min_q);
    above   = (sample_q > max_q);
    special = flat || below || above;
    span    = (bounds.upper >= bounds.lower) ? (bounds.upper - bounds.lower)
                                             : (bounds.lower - bounds.upper);
    offs    = sample_q - min_q;
    rng     = max_q - min_q;
    prod    = {{PixW{1'b0}}, span} * {{PixW{1'b0}}, offs};
    div_ctl.start = (state_q == StPrep) && !special;
    div_ctl.num   = prod;
    div_ctl.den   = rng;
    result  = spec_q ? spec_val_q : out_q;
    load_out = (state_q == StFin) && out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_acc && s_axis_tuser[0] == OpApply) state_d = StPrep;
      StPrep: state_d = special ? StFin : StDiv;
      StDiv:  if (div_sts.done) state_d = StFin;
      StFin:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      min_q    <= '1;
      max_q    <= '0;
      tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && s_axis_tuser[0] == OpMeasure) begin
        if (s_axis_tuser[1]) begin
          min_q <= s_axis_tdata;
          max_q <= s_axis_tdata;
        end else begin
          if (s_axis_tdata < min_q) min_q <= s_axis_tdata;
          if (s_axis_tdata > max_q) max_q <= s_axis_tdata;
        end
      end
      if (load_out) begin
        tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= s_axis_tdata;
    end
    if (state_q == StPrep) begin
      spec_q     <= special;
      spec_val_q <= (above && !flat) ? bounds.upper : bounds.lower;
      neg_q      <= (bounds.upper < bounds.lower);
    end
    if (div_sts.done) begin
      out_q <= neg_q ? (bounds.lower - div_sts.quo) : (bounds.lower + div_sts.quo);
    end
    if (load_out) begin
      tdata_q <= {max_q, min_q, result};
    end
  end

  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = tdata_q;

endmodule

FILE: hdl/mmcs_div.sv
// Shared shift-subtract divider producing one quotient bit per cycle.
module mmcs_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mmcs_pkg::div_ctl_t  ctl_i,
  output mmcs_pkg::div_sts_t  sts_o
);
  import mmcs_pkg::*;

  localparam logic [CntW-1:0] LastStep = CntW'(PixW - 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [PixW-1:0] r_q, r_d;
  logic [PixW-1:0] n_q, n_d;
  logic [PixW:0]   trial;
  logic [PixW+1:0] diff;
  logic            ge;

  always_comb begin
    trial = {r_q, n_q[PixW-1]};
    diff  = {1'b0, trial} - {2'b00, ctl_i.den};
    ge    = !diff[PixW+1];
    r_d   = ge ? diff[PixW-1:0] : trial[PixW-1:0];
    n_d   = {n_q[PixW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      r_q <= ctl_i.num[ProdW-1:PixW];
      n_q <= ctl_i.num[PixW-1:0];
    end else if (busy_q) begin
      r_q <= r_d;
      n_q <= n_d;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign sts_o.quo  = n_q;

endmodule

FILE: hdl/mmcs_regs.sv
// Configuration register file holding the output bounds behind an APB-style port.
module mmcs_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mmcs_pkg::AddrW-1:0]    paddr,
  input  logic [mmcs_pkg::RegW-1:0]     pwdata,
  output logic [mmcs_pkg::RegW-1:0]     prdata,
  output logic                          pready,
  output mmcs_pkg::bounds_t             bounds_o
);
  import mmcs_pkg::*;

  logic [PixW-1:0] lower_q;
  logic [PixW-1:0] upper_q;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= '0;
      upper_q <= '1;
    end else if (wr_en) begin
      case (paddr[2])
        RegLower: lower_q <= pwdata[PixW-1:0];
        RegUpper: upper_q <= pwdata[PixW-1:0];
        default:  lower_q <= lower_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegLower: prdata = {{(RegW-PixW){1'b0}}, lower_q};
      RegUpper: prdata = {{(RegW-PixW){1'b0}}, upper_q};
      default:  prdata = '0;
    endcase
  end

  assign bounds_o.lower = lower_q;
  assign bounds_o.upper = upper_q;

endmodule

FILE: hdl/mmcs_chk.sv
// Port-level checker for the min-max contrast stretch, bound to the top level.
module mmcs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("Result valid during reset.");

  a_apply_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready)
    else $error("Block still ready after accepting an apply transaction.");

  a_measure_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> s_axis_tready)
    else $error("Block not ready after a measure transaction.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled result changed.");

endmodule

bind minmax_contrast_stretch mmcs_chk u_chk (.*);

FILE: tb/stretch_checker.sv
// Checker that predicts the stretched results from the observed transactions and compares them.
module stretch_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // sample
  input  logic [1:0]  s_axis_tuser,  // operation, frame_start
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,  // stretched, frame_min, frame_max
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);
  import mmcs_pkg::*;

  typedef struct packed {
    logic [PixW-1:0] stretched;
    logic [PixW-1:0] frame_min;
    logic [PixW-1:0] frame_max;
  } pixel_result_t;

  logic [PixW-1:0] lower_q;
  logic [PixW-1:0] upper_q;
  logic [PixW-1:0] min_q;
  logic [PixW-1:0] max_q;
  logic [PixW-1:0] reg_want;
  pixel_result_t   pending_pixels[$];
  pixel_result_t   want;
  pixel_result_t   fresh;
  int              fails = 0;
  int              pending_cnt = 0;

  function automatic logic [PixW-1:0] stretch_pixel(logic [PixW-1:0] pix);
    int lo;
    int hi;
    int mn;
    int mx;
    int v;
    int q;
    lo = int'(lower_q);
    hi = int'(upper_q);
    mn = int'(min_q);
    mx = int'(max_q);
    v  = int'(pix);
    if (mx <= mn || v < mn) begin
      return lower_q;
    end
    if (v > mx) begin
      return upper_q;
    end
    q = ((hi - lo) * (v - mn)) / (mx - mn);
    return PixW'(lo + q);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q = '0;
      upper_q = '1;
      min_q   = '1;
      max_q   = '0;
      pending_pixels.delete();
      pending_cnt = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == RegLower) begin
            lower_q = pwdata[PixW-1:0];
          end else begin
            upper_q = pwdata[PixW-1:0];
          end
        end else begin
          reg_want = (paddr[2] == RegLower) ? lower_q : upper_q;
          if (prdata[PixW-1:0] != reg_want) begin
            $display("%0t register read at %0d: expected %0d actual %0d",
                     $time, paddr, reg_want, prdata[PixW-1:0]);
            fails++;
          end
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t unexpected result transaction: expected none actual %h",
                   $time, m_axis_tdata);
          fails++;
        end else begin
          want = pending_pixels.pop_front();
          if (m_axis_tdata[7:0] != want.stretched) begin
            $display("%0t stretched: expected %0d actual %0d",
                     $time, want.stretched, m_axis_tdata[7:0]);
            fails++;
          end
          if (m_axis_tdata[15:8] != want.frame_min) begin
            $display("%0t frame_min: expected %0d actual %0d",
                     $time, want.frame_min, m_axis_tdata[15:8]);
            fails++;
          end
          if (m_axis_tdata[23:16] != want.frame_max) begin
            $display("%0t frame_max: expected %0d actual %0d",
                     $time, want.frame_max, m_axis_tdata[23:16]);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == OpApply) begin
          fresh.stretched = stretch_pixel(s_axis_tdata);
          fresh.frame_min = min_q;
          fresh.frame_max = max_q;
          pending_pixels.push_back(fresh);
        end else if (s_axis_tuser[1]) begin
          min_q = s_axis_tdata;
          max_q = s_axis_tdata;
        end else begin
          if (s_axis_tdata < min_q) begin
            min_q = s_axis_tdata;
          end
          if (s_axis_tdata > max_q) begin
            max_q = s_axis_tdata;
          end
        end
      end
      pending_cnt = pending_pixels.size();
    end
  end

  assign fail_count_o = fails;
  assign pending_o    = pending_cnt;

endmodule

FILE: tb/tb_minmax_contrast_stretch.sv
// Testbench top that drives frames and bound settings into the contrast stretch and reports.
module tb_minmax_contrast_stretch;
  import mmcs_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int ItemTarget = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          cycle_cnt = 0;
  int          items_sent = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;

  minmax_contrast_stretch dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  stretch_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 2) == 0) begin
        stall_left <= pick_gap();
      end
    end
  end

  task automatic send_item(logic op, logic [7:0] pix, logic restart);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= {restart, op};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic idx, logic [7:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'b0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_bounds(logic [7:0] lo, logic [7:0] hi);
    drain();
    apb_access(1'b1, RegLower, lo);
    apb_access(1'b1, RegUpper, hi);
    apb_access(1'b0, RegLower, 8'd0);
    apb_access(1'b0, RegUpper, 8'd0);
  endtask

  initial begin
    logic [7:0] frame_pix [40];
    int         len;
    int         frames;
    int         lo_s;
    int         hi_s;
    int         pick;
    bit         restart;
    logic [7:0] pix;

    frames = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    apb_access(1'b0, RegLower, 8'd0);
    apb_access(1'b0, RegUpper, 8'd0);
    send_item(OpApply, 8'd77, 1'b0);
    send_item(OpMeasure, 8'd50, 1'b1);
    send_item(OpApply, 8'd50, 1'b0);
    send_item(OpMeasure, 8'd200, 1'b0);
    send_item(OpMeasure, 8'd10, 1'b0);
    send_item(OpApply, 8'd0, 1'b0);
    send_item(OpApply, 8'd255, 1'b0);
    send_item(OpApply, 8'd10, 1'b0);
    send_item(OpApply, 8'd200, 1'b0);
    send_item(OpApply, 8'd105, 1'b1);
    send_item(OpMeasure, 8'd0, 1'b1);
    send_item(OpMeasure, 8'd255, 1'b0);
    send_item(OpApply, 8'd1, 1'b0);
    send_item(OpApply, 8'd254, 1'b0);
    send_item(OpApply, 8'd128, 1'b0);
    set_bounds(8'd255, 8'd0);
    send_item(OpApply, 8'd0, 1'b0);
    send_item(OpApply, 8'd255, 1'b0);
    send_item(OpApply, 8'd77, 1'b0);
    set_bounds(8'd200, 8'd200);
    send_item(OpApply, 8'd99, 1'b0);
    set_bounds(8'd30, 8'd220);
    send_item(OpMeasure, 8'd100, 1'b1);
    send_item(OpMeasure, 8'd140, 1'b0);
    send_item(OpApply, 8'd99, 1'b0);
    send_item(OpApply, 8'd141, 1'b0);
    send_item(OpApply, 8'd123, 1'b0);

    while (items_sent < ItemTarget) begin
      if (frames % 3 == 0) begin
        pick = $urandom_range(0, 5);
        case (pick)
          0: begin
            set_bounds(8'd0, 8'd255);
          end
          1: begin
            set_bounds(8'd255, 8'd0);
          end
          2: begin
            pix = 8'($urandom_range(0, 255));
            set_bounds(pix, pix);
          end
          default: begin
            set_bounds(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          end
        endcase
      end
      calm = ($urandom_range(0, 4) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      lo_s = $urandom_range(0, 255);
      hi_s = $urandom_range(0, 255);
      if (lo_s > hi_s) begin
        pick = lo_s;
        lo_s = hi_s;
        hi_s = pick;
      end
      restart = ($urandom_range(0, 6) != 0);
      for (int i = 0; i < len; i++) begin
        frame_pix[i] = 8'($urandom_range(lo_s, hi_s));
        send_item(OpMeasure, frame_pix[i], restart && i == 0);
      end
      for (int i = 0; i < len; i++) begin
        pix = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : frame_pix[i];
        send_item(OpApply, pix, 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end
      end
      frames++;
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
